// ----- design/abkf_pkg.sv -----
package abkf_pkg;

  localparam int NUM_AXES   = 2;
  localparam int AXIS_W     = 1;
  localparam int DATA_WIDTH = 32;
  localparam int REG_W      = 31;
  localparam int FRAC_BITS  = 30;
  localparam int OPA_W      = 35;                  // multiplier operand A
  localparam int OPB_W      = 32;                  // multiplier operand B
  localparam int PROD_W     = OPA_W + OPB_W;
  localparam int RND_W      = PROD_W - FRAC_BITS;
  localparam int SUM_W      = RND_W + 1;
  localparam int QUO_BITS   = 33;                  // quotient bits kept before saturation
  localparam int CNT_W      = 6;

  localparam logic signed [DATA_WIDTH-1:0] ONE_Q230 = DATA_WIDTH'(64'd1 << FRAC_BITS);

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Clamp a wide signed sum to the 32-bit stored format.
  function automatic logic signed [DATA_WIDTH-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
    logic same;
    logic signed [DATA_WIDTH-1:0] r;
    same = (v[SUM_W-1:DATA_WIDTH-1] == {(SUM_W-DATA_WIDTH+1){1'b0}}) ||
           (v[SUM_W-1:DATA_WIDTH-1] == {(SUM_W-DATA_WIDTH+1){1'b1}});
    if (same) begin
      r = v[DATA_WIDTH-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ----- design/abkf_mul_unit.sv -----
module abkf_mul_unit
  import abkf_pkg::*;
(
  input  logic                    clk,
  input  logic                    issue,
  input  logic signed [OPA_W-1:0] a,
  input  logic signed [OPB_W-1:0] b,
  output logic signed [RND_W-1:0] rnd
);

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] biased;

  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(64'd1 << (FRAC_BITS - 1));

  // half away from zero: negative products add one LSB less before the floor
  assign biased = prod + (prod[PROD_W-1] ? (HALF - PROD_W'(1)) : HALF);

  always_ff @(posedge clk) begin
    if (issue) begin
      prod <= a * b;
    end
    rnd <= biased[PROD_W-1:FRAC_BITS];
  end

endmodule

// ----- design/abkf_div_unit.sv -----
module abkf_div_unit
  import abkf_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [DATA_WIDTH-1:0] p,
  input  logic        [DATA_WIDTH-1:0] e,
  output div_stat_t                    stat,
  output logic signed [DATA_WIDTH-1:0] gain
);

  logic [DATA_WIDTH-1:0] mag_start;
  logic [DATA_WIDTH-1:0] hi_start;
  logic [2:0]            mag_lo;
  logic [DATA_WIDTH-1:0] dvsr;
  logic [DATA_WIDTH-1:0] rem;
  logic [QUO_BITS-1:0]   quo;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      bitpos;
  logic                  ovf;
  logic                  neg;
  logic                  busy;
  logic                  done;
  logic                  dbit;
  logic [DATA_WIDTH:0]   trial;
  logic                  fits;

  assign mag_start = p[DATA_WIDTH-1] ? (~p + DATA_WIDTH'(1)) : p;
  assign hi_start  = mag_start >> 3;

  assign bitpos = cnt - CNT_W'(1);
  always_comb begin
    dbit = 1'b0;
    if (bitpos >= CNT_W'(FRAC_BITS)) begin
      dbit = mag_lo[2'(bitpos - CNT_W'(FRAC_BITS))];
    end
  end
  assign trial = {rem, dbit};
  assign fits  = trial >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start && !busy) begin
        busy <= 1'b1;
      end else if (busy && (cnt == CNT_W'(1))) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      // quotient >= 2^33 exactly when the top dividend bits already reach e
      mag_lo <= mag_start[2:0];
      dvsr   <= e;
      rem    <= hi_start;
      ovf    <= hi_start >= e;
      neg    <= p[DATA_WIDTH-1];
      quo    <= '0;
      cnt    <= CNT_W'(QUO_BITS);
    end else if (busy) begin
      rem <= fits ? DATA_WIDTH'(trial - {1'b0, dvsr}) : trial[DATA_WIDTH-1:0];
      quo <= {quo[QUO_BITS-2:0], fits};
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_comb begin
    if (neg) begin
      if (ovf || (quo > QUO_BITS'(64'd1 << (DATA_WIDTH - 1)))) begin
        gain = {1'b1, {(DATA_WIDTH-1){1'b0}}};
      end else begin
        gain = DATA_WIDTH'(~quo + QUO_BITS'(1));
      end
    end else begin
      if (ovf || (quo > QUO_BITS'((64'd1 << (DATA_WIDTH - 1)) - 1))) begin
        gain = {1'b0, {(DATA_WIDTH-1){1'b1}}};
      end else begin
        gain = quo[DATA_WIDTH-1:0];
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ----- design/angle_bias_kalman_filter_unit.sv -----
// Channel  Direction  Handshake          Payload
// in       sink       in_valid/in_stall   axis, accel_angle, gyro_rate
// out      source     out_valid/out_stall axis_out, angle_out, rate_out
// cfg      APB slave  psel/penable/pready paddr[3:2] register, pwdata/prdata
//
// An item runs ten multiply steps through the single shared multiplier, each
// passing the S_MUL, S_RND and S_ACC states, two gain divisions (one quotient
// bit a cycle, 33 bits), plus the load and finish states.
// in_stall is high from acceptance until the result is placed in the output
// register; a waiting result does not block the next item from being taken.
// rst is synchronous: per-axis state returns to angle 0, bias 0, P = identity,
// and the registers take their default noise and period values.
module angle_bias_kalman_filter_unit
  import abkf_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic        [AXIS_W-1:0]     axis,
  input  logic signed [DATA_WIDTH-1:0] accel_angle,
  input  logic signed [DATA_WIDTH-1:0] gyro_rate,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic        [AXIS_W-1:0]     axis_out,
  output logic signed [DATA_WIDTH-1:0] angle_out,
  output logic signed [DATA_WIDTH-1:0] rate_out,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic        [3:0]            paddr,
  input  logic        [31:0]           pwdata,
  output logic        [31:0]           prdata,
  output logic                         pready
);

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
  localparam logic [1:0] REG_BIAS_NOISE  = 2'd1;
  localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;
  localparam logic [1:0] REG_PERIOD      = 2'd3;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_LOAD = 8'b0000_0010,
    S_MUL  = 8'b0000_0100,
    S_RND  = 8'b0000_1000,
    S_ACC  = 8'b0001_0000,
    S_DIVS = 8'b0010_0000,
    S_DIVW = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  logic [REG_W-1:0] angle_noise;
  logic [REG_W-1:0] bias_noise;
  logic [REG_W-1:0] meas_noise;
  logic [REG_W-1:0] period;

  // per-axis filter state
  logic signed [DATA_WIDTH-1:0] angle_est [NUM_AXES];
  logic signed [DATA_WIDTH-1:0] bias_est  [NUM_AXES];
  logic signed [DATA_WIDTH-1:0] cov_aa    [NUM_AXES];
  logic signed [DATA_WIDTH-1:0] cov_ab    [NUM_AXES];
  logic signed [DATA_WIDTH-1:0] cov_ba    [NUM_AXES];
  logic signed [DATA_WIDTH-1:0] cov_bb    [NUM_AXES];

  // working copy of the selected axis
  logic        [AXIS_W-1:0]     axis_r;
  logic signed [DATA_WIDTH-1:0] acc_r;
  logic signed [DATA_WIDTH-1:0] gyr_r;
  logic signed [DATA_WIDTH-1:0] wa;
  logic signed [DATA_WIDTH-1:0] wb;
  logic signed [DATA_WIDTH-1:0] p00;
  logic signed [DATA_WIDTH-1:0] p01;
  logic signed [DATA_WIDTH-1:0] p10;
  logic signed [DATA_WIDTH-1:0] p11;
  logic signed [DATA_WIDTH-1:0] t0;
  logic signed [DATA_WIDTH-1:0] t1;
  logic signed [DATA_WIDTH-1:0] rate_pre;
  logic signed [DATA_WIDTH+1:0] d0;
  logic signed [DATA_WIDTH:0]   neg_p11;
  logic signed [DATA_WIDTH:0]   err;
  logic signed [DATA_WIDTH-1:0] k0;
  logic signed [DATA_WIDTH-1:0] k1;
  logic [3:0]                   step;
  logic                         div_sel;

  logic signed [OPA_W-1:0] mul_a;
  logic signed [OPB_W-1:0] mul_b;
  logic signed [RND_W-1:0] rnd;
  logic signed [DATA_WIDTH-1:0] acc_base;
  logic signed [SUM_W-1:0]      acc_sum;
  logic signed [DATA_WIDTH-1:0] acc_sat;

  logic signed [DATA_WIDTH:0]   e_sum;
  logic        [DATA_WIDTH-1:0] e_div;
  div_stat_t                    div_stat;
  logic signed [DATA_WIDTH-1:0] div_gain;
  logic signed [DATA_WIDTH-1:0] rate_fin;

  logic in_take;
  logic cfg_wr;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_noise <= REG_W'(1073742);
      bias_noise  <= REG_W'(3221225);
      meas_noise  <= REG_W'(536870912);
      period      <= REG_W'(10737418);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ANGLE_NOISE: angle_noise <= pwdata[REG_W-1:0];
        REG_BIAS_NOISE:  bias_noise  <= pwdata[REG_W-1:0];
        REG_MEAS_NOISE:  meas_noise  <= pwdata[REG_W-1:0];
        REG_PERIOD:      period      <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ANGLE_NOISE: prdata = {1'b0, angle_noise};
      REG_BIAS_NOISE:  prdata = {1'b0, bias_noise};
      REG_MEAS_NOISE:  prdata = {1'b0, meas_noise};
      REG_PERIOD:      prdata = {1'b0, period};
      default:         prdata = '0;
    endcase
  end

  // ---------------- shared multiplier ----------------
  // steps 0-3 predict, 4-7 update covariance, 8-9 correct angle and bias
  always_comb begin
    mul_a    = OPA_W'(rate_pre);
    mul_b    = {1'b0, period};
    acc_base = wa;
    case (step)
      4'd0: begin
        mul_a = OPA_W'(rate_pre);
        mul_b = {1'b0, period};
        acc_base = wa;
      end
      4'd1: begin
        mul_a = OPA_W'(d0);
        mul_b = {1'b0, period};
        acc_base = p00;
      end
      4'd2: begin
        mul_a = OPA_W'(neg_p11);
        mul_b = {1'b0, period};
        acc_base = p01;
      end
      4'd3: begin
        mul_a = OPA_W'({1'b0, bias_noise});
        mul_b = {1'b0, period};
        acc_base = p11;
      end
      4'd4: begin
        mul_a = OPA_W'(k0);
        mul_b = t0;
        acc_base = p00;
      end
      4'd5: begin
        mul_a = OPA_W'(k0);
        mul_b = t1;
        acc_base = p01;
      end
      4'd6: begin
        mul_a = OPA_W'(k1);
        mul_b = t0;
        acc_base = p10;
      end
      4'd7: begin
        mul_a = OPA_W'(k1);
        mul_b = t1;
        acc_base = p11;
      end
      4'd8: begin
        mul_a = OPA_W'(err);
        mul_b = k0;
        acc_base = wa;
      end
      4'd9: begin
        mul_a = OPA_W'(err);
        mul_b = k1;
        acc_base = wb;
      end
      default: ;
    endcase
  end

  abkf_mul_unit u_mul (
    .clk   (clk),
    .issue (state == S_MUL),
    .a     (mul_a),
    .b     (mul_b),
    .rnd   (rnd)
  );

  // covariance update steps subtract, the rest add
  assign acc_sum = ((step >= 4'd4) && (step <= 4'd7)) ?
                   (SUM_W'(acc_base) - SUM_W'(rnd)) : (SUM_W'(acc_base) + SUM_W'(rnd));
  assign acc_sat = sat_sum(acc_sum);

  // ---------------- gain divider ----------------
  assign e_sum = $signed({2'b00, meas_noise}) + (DATA_WIDTH+1)'(p00);
  assign e_div = (e_sum < (DATA_WIDTH+1)'(1)) ? DATA_WIDTH'(1) : e_sum[DATA_WIDTH-1:0];

  abkf_div_unit u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_DIVS),
    .p     (div_sel ? p10 : p00),
    .e     (e_div),
    .stat  (div_stat),
    .gain  (div_gain)
  );

  assign rate_fin = sat_sum(SUM_W'(gyr_r) - SUM_W'(wb));

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_take) state_next = S_LOAD;
      S_LOAD: state_next = S_MUL;
      S_MUL:  state_next = S_RND;
      S_RND:  state_next = S_ACC;
      S_ACC: begin
        if (step == 4'd3) begin
          state_next = S_DIVS;
        end else if (step == 4'd9) begin
          state_next = S_FIN;
        end else begin
          state_next = S_MUL;
        end
      end
      S_DIVS: state_next = S_DIVW;
      S_DIVW: begin
        if (div_stat.done) state_next = div_sel ? S_MUL : S_DIVS;
      end
      S_FIN:  if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        axis_r <= axis;
        acc_r  <= accel_angle;
        gyr_r  <= gyro_rate;
        wa     <= angle_est[axis];
        wb     <= bias_est[axis];
        p00    <= cov_aa[axis];
        p01    <= cov_ab[axis];
        p10    <= cov_ba[axis];
        p11    <= cov_bb[axis];
        step   <= 4'd0;
      end
      S_LOAD: begin
        rate_pre <= sat_sum(SUM_W'(gyr_r) - SUM_W'(wb));
        d0       <= $signed({3'b000, angle_noise}) - (DATA_WIDTH+2)'(p01) -
                    (DATA_WIDTH+2)'(p10);
        neg_p11  <= -((DATA_WIDTH+1)'(p11));
        div_sel  <= 1'b0;
      end
      S_ACC: begin
        case (step)
          4'd0, 4'd8: wa  <= acc_sat;
          4'd1, 4'd4: p00 <= acc_sat;
          4'd2: begin
            // same rounded product feeds both cross terms
            p01 <= acc_sat;
            p10 <= sat_sum(SUM_W'(p10) + SUM_W'(rnd));
          end
          4'd3, 4'd7: p11 <= acc_sat;
          4'd5: p01 <= acc_sat;
          4'd6: p10 <= acc_sat;
          4'd9: wb  <= acc_sat;
          default: ;
        endcase
        if (step != 4'd3) step <= step + 4'd1;
      end
      S_DIVS: begin
        t0  <= p00;
        t1  <= p01;
        err <= (DATA_WIDTH+1)'(acc_r) - (DATA_WIDTH+1)'(wa);
      end
      S_DIVW: begin
        if (div_stat.done) begin
          if (div_sel) begin
            k1   <= div_gain;
            step <= 4'd4;
          end else begin
            k0      <= div_gain;
            div_sel <= 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // write-back of the per-axis state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        angle_est[i] <= '0;
        bias_est[i]  <= '0;
        cov_aa[i]    <= ONE_Q230;
        cov_ab[i]    <= '0;
        cov_ba[i]    <= '0;
        cov_bb[i]    <= ONE_Q230;
      end
    end else if ((state == S_FIN) && (state_next == S_IDLE)) begin
      angle_est[axis_r] <= wa;
      bias_est[axis_r]  <= wb;
      cov_aa[axis_r]    <= p00;
      cov_ab[axis_r]    <= p01;
      cov_ba[axis_r]    <= p10;
      cov_bb[axis_r]    <= p11;
    end
  end

  // output register: a result waits here while the next item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_FIN) && (state_next == S_IDLE)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FIN) && (state_next == S_IDLE)) begin
      axis_out  <= axis_r;
      angle_out <= wa;
      rate_out  <= rate_fin;
    end
  end

`ifndef SYNTH
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_take |=> in_stall)
    else $error("block not busy after taking an item");

  a_div_only_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> (state == S_DIVW))
    else $error("divider running outside its wait state");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FIN))
    else $error("result shown without finishing an item");
`endif

endmodule

// ----- dv/tb_angle_bias_kalman_filter_unit.sv -----
module tb_angle_bias_kalman_filter_unit
  import abkf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // register indexes, byte address is 4*index
  typedef enum int {
    REG_ANGLE_NOISE = 0,
    REG_BIAS_NOISE  = 1,
    REG_MEAS_NOISE  = 2,
    REG_PERIOD      = 3
  } reg_idx_e;

  localparam longint Q30_ONE = 64'sd1 << 30;
  localparam longint MAG_MAX = 64'sd1 << 62;

  // Expected filter output for one item
  typedef struct {
    logic [AXIS_W-1:0]            axis;
    logic signed [DATA_WIDTH-1:0] angle;
    logic signed [DATA_WIDTH-1:0] rate;
  } filt_out_t;

  // Per-axis Kalman model plus the queue of outputs still to come
  class kalman_scoreboard;
    longint    noise_a, noise_b, noise_m, period;
    longint    ang[NUM_AXES], bias[NUM_AXES];
    longint    paa[NUM_AXES], pab[NUM_AXES], pba[NUM_AXES], pbb[NUM_AXES];
    filt_out_t pending_outs[$];
    int        mismatches;

    function void reset_state();
      noise_a = 1073742;
      noise_b = 3221225;
      noise_m = 536870912;
      period  = 10737418;
      for (int i = 0; i < NUM_AXES; i++) begin
        ang[i] = 0; bias[i] = 0;
        paa[i] = Q30_ONE; pab[i] = 0; pba[i] = 0; pbb[i] = Q30_ONE;
      end
      pending_outs.delete();
      mismatches = 0;
    endfunction

    function void set_reg(reg_idx_e idx, longint val);
      case (idx)
        REG_ANGLE_NOISE: noise_a = val & 64'h7FFF_FFFF;
        REG_BIAS_NOISE:  noise_b = val & 64'h7FFF_FFFF;
        REG_MEAS_NOISE:  noise_m = val & 64'h7FFF_FFFF;
        REG_PERIOD:      period  = val & 64'h7FFF_FFFF;
        default: ;
      endcase
    endfunction

    function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // (a*b)/2^30, round half away from zero, magnitude capped
    function longint mul_q30(longint a, longint b);
      bit           neg;
      logic [127:0] ua, ub, prod;
      neg  = (a < 0) != (b < 0);
      ua   = (a < 0) ? 128'(-a) : 128'(a);
      ub   = (b < 0) ? 128'(-b) : 128'(b);
      prod = ((ua * ub) + (128'd1 << 29)) >> 30;
      if (prod > 128'(MAG_MAX)) prod = 128'(MAG_MAX);
      return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    function longint kgain(longint p, longint e);
      return sat32((p * Q30_ONE) / e);
    endfunction

    function void note_item(logic [AXIS_W-1:0] ax, logic signed [DATA_WIDTH-1:0] acc,
                            logic signed [DATA_WIDTH-1:0] gyr);
      longint    a, b, p00, p01, p10, p11, rt, err, e, k0, k1, d0;
      int        i;
      filt_out_t r;
      i = ax;
      r.axis = ax;
      a = ang[i]; b = bias[i];
      p00 = paa[i]; p01 = pab[i]; p10 = pba[i]; p11 = pbb[i];
      // predict
      rt  = sat32(longint'(gyr) - b);
      a   = sat32(a + mul_q30(rt, period));
      d0  = noise_a - p01 - p10;
      p00 = sat32(p00 + mul_q30(d0, period));
      p01 = sat32(p01 + mul_q30(-p11, period));
      p10 = sat32(p10 + mul_q30(-p11, period));
      p11 = sat32(p11 + mul_q30(noise_b, period));
      // correct; divisor floored at one LSB
      err = longint'(acc) - a;
      e   = noise_m + p00;
      if (e < 1) e = 1;
      k0 = kgain(p00, e);
      k1 = kgain(p10, e);
      paa[i] = sat32(p00 - mul_q30(k0, p00));
      pab[i] = sat32(p01 - mul_q30(k0, p01));
      pba[i] = sat32(p10 - mul_q30(k1, p00));
      pbb[i] = sat32(p11 - mul_q30(k1, p01));
      a = sat32(a + mul_q30(k0, err));
      b = sat32(b + mul_q30(k1, err));
      ang[i] = a; bias[i] = b;
      rt = sat32(longint'(gyr) - b);
      r.angle = a[31:0];
      r.rate  = rt[31:0];
      pending_outs.push_back(r);
    endfunction

    function void check_out(logic [AXIS_W-1:0] ax, logic signed [DATA_WIDTH-1:0] an,
                            logic signed [DATA_WIDTH-1:0] rt);
      filt_out_t x;
      if (pending_outs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected output axis=%0d angle=%0d", ax, an);
        return;
      end
      x = pending_outs.pop_front();
      if (x.axis !== ax || x.angle !== an || x.rate !== rt) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: exp axis=%0d angle=%0d rate=%0d, got axis=%0d angle=%0d rate=%0d",
                   x.axis, x.angle, x.rate, ax, an, rt);
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic        [AXIS_W-1:0]     axis = '0;
  logic signed [DATA_WIDTH-1:0] accel_angle = '0;
  logic signed [DATA_WIDTH-1:0] gyro_rate = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic        [AXIS_W-1:0]     axis_out;
  logic signed [DATA_WIDTH-1:0] angle_out;
  logic signed [DATA_WIDTH-1:0] rate_out;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic        [3:0]            paddr = '0;
  logic        [31:0]           pwdata = '0;
  logic        [31:0]           prdata;
  logic                         pready;

  kalman_scoreboard sb;
  bit               quiet = 1'b0;   // final stretch: no idling on either side
  bit               ran_ok = 1'b0;

  always #6 clk = ~clk;

  angle_bias_kalman_filter_unit dut (.*);

  // Output monitor: compare every accepted result
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_out(axis_out, angle_out, rate_out);
  end

  // Receiver stalls in bursts, with calm stretches in between
  int stall_left = 0;
  int calm_left  = 0;
  always @(posedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (calm_left > 0) begin
      calm_left <= calm_left - 1;
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_stall  <= 1'b1;
    end else begin
      calm_left <= $urandom_range(0, 1) ? $urandom_range(20, 300) : 0;
      out_stall <= 1'b0;
    end
  end

  // APB write: setup cycle then access cycle
  task automatic reg_write(reg_idx_e idx, logic [31:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 4'(idx * 4);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // Present one item, hold it until taken. Optional idle burst first.
  task automatic send_item(logic [AXIS_W-1:0] ax, logic signed [DATA_WIDTH-1:0] acc,
                           logic signed [DATA_WIDTH-1:0] gyr);
    if (!quiet && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    axis        <= ax;
    accel_angle <= acc;
    gyro_rate   <= gyr;
    do @(posedge clk); while (in_stall);
    sb.note_item(ax, acc, gyr);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_outs.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);   // one full item time of slack
  endtask

  // Mostly realistic tilt/rate pairs, some full-range noise
  task automatic random_items(int n);
    logic signed [DATA_WIDTH-1:0] acc, gyr;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 4) == 0) begin
        acc = $urandom;
        gyr = $urandom;
      end else begin
        acc = $signed($urandom_range(0, 2 * 90 * 65536)) - 90 * 65536;
        gyr = $signed($urandom_range(0, 2 * 500 * 65536)) - 500 * 65536;
      end
      send_item(AXIS_W'($urandom_range(0, 1)), acc, gyr);
    end
  endtask

  task automatic write_all(logic [31:0] na, logic [31:0] nb, logic [31:0] nm,
                           logic [31:0] per);
    reg_write(REG_ANGLE_NOISE, na);
    reg_write(REG_BIAS_NOISE, nb);
    reg_write(REG_MEAS_NOISE, nm);
    reg_write(REG_PERIOD, per);
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes on both axes, zero, and settling on a constant tilt
    send_item(1'b0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_item(1'b1, -32'sh8000_0000, -32'sh8000_0000);
    send_item(1'b0, -32'sh8000_0000, 32'sh7FFF_FFFF);
    send_item(1'b1, 32'sh7FFF_FFFF, -32'sh8000_0000);
    send_item(1'b0, 0, 0);
    send_item(1'b1, 0, 0);
    send_item(1'b0, -1, 1);
    send_item(1'b1, 1, -1);
    for (int k = 0; k < 6; k++) send_item(AXIS_W'(k & 1), 30 * 65536, 2 * 65536);
    drain();

    // smallest measurement noise and period, zero process noise
    write_all(0, 0, 1, 1);
    send_item(1'b0, 45 * 65536, -10 * 65536);
    send_item(1'b1, -45 * 65536, 10 * 65536);
    random_items(200);
    drain();

    // everything at its maximum: covariance saturates, divisor may floor out
    write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    random_items(150);
    drain();

    // large process noise with tiny measurement noise
    write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 32'h4000_0000);
    random_items(150);
    drain();

    // several random settings
    for (int ph = 0; ph < 4; ph++) begin
      write_all($urandom_range(0, 32'h7FFF_FFFF), $urandom_range(0, 32'h7FFF_FFFF),
                $urandom_range(1, 32'h7FFF_FFFF), $urandom_range(1, 32'h7FFF_FFFF));
      random_items(150);
      drain();
    end

    // back to defaults, last stretch with no idling anywhere
    write_all(1073742, 3221225, 536870912, 10737418);
    random_items(150);
    quiet = 1'b1;
    random_items(200);
    drain();

    if (sb.mismatches == 0 && sb.pending_outs.size() == 0) ran_ok = 1'b1;
    if (ran_ok) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #40_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/abkf_pkg.sv
design/abkf_mul_unit.sv
design/abkf_div_unit.sv
design/angle_bias_kalman_filter_unit.sv
dv/tb_angle_bias_kalman_filter_unit.sv
